// File: sv/ptzf_pkg.sv
// Shared types and constants of the PTZ command framer.
// Holds the item, frame, configuration and state structs and the code enums.
// No dependencies; every other file uses this package by scoped names.
package ptzf_pkg;

    localparam logic [3:0] MAX_STOP_COPIES = 4'd10;

    localparam logic [7:0] CMD_PAN_LEFT      = 8'h04;
    localparam logic [7:0] CMD_PAN_RIGHT     = 8'h02;
    localparam logic [7:0] CMD_TILT_UP       = 8'h08;
    localparam logic [7:0] CMD_TILT_DOWN     = 8'h10;
    localparam logic [7:0] CMD_ZOOM_TELE     = 8'h20;
    localparam logic [7:0] CMD_ZOOM_WIDE     = 8'h40;
    localparam logic [7:0] CMD_FOCUS_NEAR    = 8'h01;
    localparam logic [7:0] CMD_FOCUS_FAR     = 8'h80;
    localparam logic [7:0] CMD_PRESET_STORE  = 8'h03;
    localparam logic [7:0] CMD_PRESET_RECALL = 8'h07;
    localparam logic [7:0] CMD_PRESET_CLR    = 8'h05;

    typedef enum logic [2:0] {
        MODE_MOVE     = 3'd0,
        MODE_STOP     = 3'd1,
        MODE_PRESET   = 3'd2,
        MODE_TICK     = 3'd3,
        MODE_SHUTDOWN = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        AXIS_PAN   = 2'd0,
        AXIS_TILT  = 2'd1,
        AXIS_ZOOM  = 2'd2,
        AXIS_FOCUS = 2'd3
    } axis_t;

    typedef enum logic [1:0] {
        PRESET_STORE   = 2'd0,
        PRESET_RECALL  = 2'd1,
        PRESET_ERASE   = 2'd2,
        PRESET_INVALID = 2'd3
    } preset_op_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_STOP   = 2'd1,
        STATUS_BAD_PRESET = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_PAN_RATE       = 2'd1,
        REG_TILT_RATE      = 2'd2,
        REG_STOP_COPIES    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  axis;
        logic        direction;
        logic [31:0] run_time_ms;
        logic [3:0]  stop_mask;
        logic [1:0]  preset_op;
        logic [7:0]  preset_number;
    } item_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic [5:0] pan_rate;
        logic [5:0] tilt_rate;
        logic [3:0] stop_copies;
    } cfg_t;

    typedef struct packed {
        logic        moving;
        logic [31:0] remaining_ms;
        logic        armed;
    } motion_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] address_byte;
        logic [7:0] command_one;
        logic [7:0] command_two;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic [7:0] frame_sum;
        logic       motion_done;
    } frame_t;

endpackage

// File: sv/ptzf_decode.sv
// Command decoder of the PTZ command framer: builds one frame, its copy count
// and the next motion state from an item, the registers and the current state.
// Depends on ptzf_pkg.
module ptzf_decode (
    input  ptzf_pkg::item_t   item,
    input  ptzf_pkg::cfg_t    cfg,
    input  ptzf_pkg::motion_t motion,
    output ptzf_pkg::frame_t  frame,
    output logic              emit,
    output logic [3:0]        copies,
    output ptzf_pkg::motion_t motion_next
);

    always_comb
    begin
        logic [1:0]  status;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic        ended;
        logic        burst;
        logic [31:0] rem_dec;
        logic [3:0]  burst_len;

        status      = ptzf_pkg::STATUS_OK;
        c1          = 8'h00;
        c2          = 8'h00;
        d1          = 8'h00;
        d2          = 8'h00;
        ended       = 1'b0;
        burst       = 1'b0;
        emit        = 1'b0;
        motion_next = motion;
        rem_dec     = (motion.remaining_ms != 32'd0) ? motion.remaining_ms - 32'd1
                                                     : motion.remaining_ms;

        if (cfg.stop_copies == 4'd0)
        begin
            burst_len = 4'd1;
        end
        else if (cfg.stop_copies > ptzf_pkg::MAX_STOP_COPIES)
        begin
            burst_len = ptzf_pkg::MAX_STOP_COPIES;
        end
        else
        begin
            burst_len = cfg.stop_copies;
        end

        unique case (item.mode)
            ptzf_pkg::MODE_MOVE:
            begin
                emit = 1'b1;
                unique case (item.axis)
                    ptzf_pkg::AXIS_PAN:
                    begin
                        c2 = item.direction ? ptzf_pkg::CMD_PAN_RIGHT : ptzf_pkg::CMD_PAN_LEFT;
                        d1 = {2'b00, cfg.pan_rate};
                    end
                    ptzf_pkg::AXIS_TILT:
                    begin
                        c2 = item.direction ? ptzf_pkg::CMD_TILT_DOWN : ptzf_pkg::CMD_TILT_UP;
                        d2 = {2'b00, cfg.tilt_rate};
                    end
                    ptzf_pkg::AXIS_ZOOM:
                    begin
                        c2 = item.direction ? ptzf_pkg::CMD_ZOOM_WIDE : ptzf_pkg::CMD_ZOOM_TELE;
                    end
                    default:
                    begin
                        if (item.direction)
                        begin
                            c2 = ptzf_pkg::CMD_FOCUS_FAR;
                        end
                        else
                        begin
                            c1 = ptzf_pkg::CMD_FOCUS_NEAR;
                        end
                    end
                endcase
                motion_next.moving       = 1'b1;
                motion_next.remaining_ms = item.run_time_ms;
                motion_next.armed        = (item.run_time_ms != 32'd0);
            end
            ptzf_pkg::MODE_STOP:
            begin
                emit = 1'b1;
                if (item.stop_mask == 4'd0)
                begin
                    status = ptzf_pkg::STATUS_BAD_STOP;
                end
                else
                begin
                    burst = 1'b1;
                end
            end
            ptzf_pkg::MODE_PRESET:
            begin
                emit = 1'b1;
                if (item.preset_op == ptzf_pkg::PRESET_INVALID || item.preset_number == 8'd0)
                begin
                    status = ptzf_pkg::STATUS_BAD_PRESET;
                end
                else
                begin
                    unique case (item.preset_op)
                        ptzf_pkg::PRESET_STORE:  c2 = ptzf_pkg::CMD_PRESET_STORE;
                        ptzf_pkg::PRESET_RECALL: c2 = ptzf_pkg::CMD_PRESET_RECALL;
                        default:                 c2 = ptzf_pkg::CMD_PRESET_CLR;
                    endcase
                    d2 = item.preset_number;
                end
            end
            ptzf_pkg::MODE_TICK:
            begin
                if (motion.armed)
                begin
                    motion_next.remaining_ms = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        emit  = 1'b1;
                        burst = 1'b1;
                        ended = 1'b1;
                    end
                end
            end
            ptzf_pkg::MODE_SHUTDOWN:
            begin
                if (motion.moving)
                begin
                    emit  = 1'b1;
                    burst = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (burst)
        begin
            motion_next.moving       = 1'b0;
            motion_next.armed        = 1'b0;
            motion_next.remaining_ms = 32'd0;
        end
        copies = burst ? burst_len : 4'd1;

        frame.status         = status;
        frame.address_byte   = (status == ptzf_pkg::STATUS_OK) ? cfg.device_address : 8'h00;
        frame.command_one    = c1;
        frame.command_two    = c2;
        frame.data_one       = d1;
        frame.data_two       = d2;
        frame.frame_sum      = (status == ptzf_pkg::STATUS_OK)
                             ? 8'(cfg.device_address + c1 + c2 + d1 + d2) : 8'h00;
        frame.motion_done    = ended;
    end

endmodule

// File: sv/ptz_command_framer_core.sv
// PTZ command framer: turns camera commands on an input stream into frame
// bytes on an output stream. Holds registers, motion state and the result stage.
// Depends on ptzf_pkg and ptzf_decode.
//
// Usage:
//   Commands enter on the s_ channel, one per transfer; the mode rides in
//   s_tuser and the remaining command fields in s_tdata. Each result is one
//   frame (bytes one to five and the checksum; the 0xFF sync byte is left to
//   the serializer) on the m_ channel, with status and the motion-done flag
//   in m_tuser and m_tlast on the final frame of a command.
//   Registers must be written on the cfg_ channel only while no command is in
//   flight; the block does not enforce this. cfg_ready is always high.
//   A command's first frame appears in the cycle after its input transfer. One
//   command is accepted per cycle while the output is free or being taken.
//   A stop burst of N copies holds off new commands during its first N - 1
//   output transfers, counted by the burst counter in the result stage; the
//   next command can be accepted in the cycle that the last copy is taken.
//   Ticks and shutdowns that cause no frame are accepted without output.
//   Reset restores the register defaults and clears the motion state and the
//   result stage's valid, last and burst state, not its frame data. When the
//   receiver stalls, the pending frame holds and s_tready falls until taken.
module ptz_command_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: axis[1:0], direction[2], run_time_ms[34:3],
    // stop_mask[38:35], preset_op[40:39], preset_number[48:41], zero fill.
    input  logic [55:0] s_tdata,
    // Fields from bit 0: mode[2:0].
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: address_byte, command_one, command_two, data_one,
    // data_two, frame_sum, eight bits each.
    output logic [47:0] m_tdata,
    // Fields from bit 0: status[1:0], motion_done[2].
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    ptzf_pkg::cfg_t    cfg_reg;
    ptzf_pkg::motion_t motion_reg;
    ptzf_pkg::motion_t motion_next;
    ptzf_pkg::frame_t  frame_reg;
    ptzf_pkg::frame_t  frame_next;
    ptzf_pkg::item_t   item;
    logic              out_valid_reg;
    logic              last_reg;
    logic [3:0]        burst_left_reg;
    logic              emit;
    logic [3:0]        copies;
    logic              accept;
    logic              taken;

    assign item.mode          = s_tuser;
    assign item.axis          = s_tdata[1:0];
    assign item.direction     = s_tdata[2];
    assign item.run_time_ms   = s_tdata[34:3];
    assign item.stop_mask     = s_tdata[38:35];
    assign item.preset_op     = s_tdata[40:39];
    assign item.preset_number = s_tdata[48:41];

    assign cfg_ready = 1'b1;
    assign s_tready  = (burst_left_reg == 4'd0) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign taken     = out_valid_reg && m_tready;

    ptzf_decode u_decode (
        .item        (item),
        .cfg         (cfg_reg),
        .motion      (motion_reg),
        .frame       (frame_next),
        .emit        (emit),
        .copies      (copies),
        .motion_next (motion_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= 8'd1;
            cfg_reg.pan_rate       <= 6'd32;
            cfg_reg.tilt_rate      <= 6'd32;
            cfg_reg.stop_copies    <= 4'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ptzf_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                ptzf_pkg::REG_PAN_RATE:       cfg_reg.pan_rate       <= cfg_data[5:0];
                ptzf_pkg::REG_TILT_RATE:      cfg_reg.tilt_rate      <= cfg_data[5:0];
                default:                      cfg_reg.stop_copies    <= cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg     <= '0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
            burst_left_reg <= 4'd0;
        end
        else if (accept)
        begin
            motion_reg    <= motion_next;
            out_valid_reg <= emit;
            if (emit)
            begin
                burst_left_reg <= copies - 4'd1;
                last_reg       <= (copies == 4'd1);
            end
        end
        else if (taken)
        begin
            if (burst_left_reg != 4'd0)
            begin
                burst_left_reg <= burst_left_reg - 4'd1;
                last_reg       <= (burst_left_reg == 4'd1);
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            frame_reg <= frame_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {frame_reg.motion_done, frame_reg.status};
    assign m_tdata  = {frame_reg.frame_sum, frame_reg.data_two, frame_reg.data_one,
                       frame_reg.command_two, frame_reg.command_one, frame_reg.address_byte};

`ifndef SYNTH
    a_burst_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_left_reg != 4'd0) |-> out_valid_reg)
        else $error("burst counter running without a pending frame");

    a_burst_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && burst_left_reg != 4'd0) |=> (m_tvalid && $stable(m_tdata)
                                              && $stable(m_tuser)))
        else $error("stop burst copy differs from the previous frame");

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_reg.status != ptzf_pkg::STATUS_OK)
        |-> (last_reg && burst_left_reg == 4'd0))
        else $error("rejected command produced more than one frame");

    a_armed_count: assert property (@(posedge clk) disable iff (!rst_n)
        motion_reg.armed == (motion_reg.remaining_ms != 32'd0))
        else $error("timer armed flag and countdown disagree");

    a_armed_moving: assert property (@(posedge clk) disable iff (!rst_n)
        motion_reg.armed |-> motion_reg.moving)
        else $error("timer armed while not moving");
`endif

endmodule
